[hdl/htr_pkg.sv]
// ----------------------------------------------------------------------------
// htr_pkg
// Shared types and constants for the haze transmission recovery unit.
// ----------------------------------------------------------------------------
package htr_pkg;

   // default sizing
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int PATCH_SIZE_DEF = 3;

   // field widths
   localparam int CHAN_W     = 8;
   localparam int PIXEL_W    = 3 * CHAN_W;
   localparam int Q16_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SIZE_REG_W = 11;

   // shared divider sizing
   localparam int DIV_DVD_W = 25;
   localparam int DIV_DVS_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATMOS_LIGHT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OMEGA        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_T_FLOOR      = 3'd4;

   // register reset values
   localparam logic [SIZE_REG_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
   localparam logic [SIZE_REG_W-1:0] RST_FRAME_HEIGHT = 11'd768;
   localparam logic [CHAN_W-1:0]     RST_ATMOS_LIGHT  = 8'd255;
   localparam logic [Q16_W-1:0]      RST_OMEGA        = 16'd62259;
   localparam logic [Q16_W-1:0]      RST_T_FLOOR      = 16'd6554;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_LATCH,
      S_WRITE,
      S_CHECK,
      S_RADDR,
      S_RDATA,
      S_MUL,
      S_DIVA_GO,
      S_DIVA_WAIT,
      S_DIVC_GO,
      S_DIVC_WAIT,
      S_DONE
   } htr_state_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } htr_div_stat_type;

   // smallest of three channels
   function automatic logic [CHAN_W-1:0] min3(input logic [PIXEL_W-1:0] px);
      logic [CHAN_W-1:0] m;
      m = px[CHAN_W-1:0];
      if (px[2*CHAN_W-1:CHAN_W] < m) m = px[2*CHAN_W-1:CHAN_W];
      if (px[3*CHAN_W-1:2*CHAN_W] < m) m = px[3*CHAN_W-1:2*CHAN_W];
      return m;
   endfunction

endpackage

[hdl/htr_div.sv]
// ----------------------------------------------------------------------------
// htr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module htr_div
   import htr_pkg::*;
#(
   parameter int DW = DIV_DVD_W,
   parameter int VW = DIV_DVS_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DW-1:0]    dividend,
   input  logic [VW-1:0]    divisor,
   output logic [DW-1:0]    quotient,
   output htr_div_stat_type stat
);

   localparam int CW = $clog2(DW + 1);

   logic [VW-1:0] rem_ff;
   logic [DW-1:0] quo_ff;
   logic [VW-1:0] dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [VW:0]   shifted;
   logic          ge;
   logic [VW:0]   diff;

   // trial subtract of the next bit
   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      diff    = shifted - {1'b0, dvs_ff};
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[VW-1:0] : shifted[VW-1:0];
         quo_ff <= {quo_ff[DW-2:0], ge};
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[hdl/haze_transmission_recovery_unit.sv]
// ----------------------------------------------------------------------------
// haze_transmission_recovery_unit
// Dark channel prior dehaze on a raster RGB pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order, one transfer each; tuser
// set marks a flush transfer that carries no pixel and only drains the tail
// of the frame. Results leave on the rsp_ channel, delayed by PATCH_SIZE/2
// rows plus PATCH_SIZE/2 pixels; tlast marks the frame's final result.
// Registers on the csr_ channel are sampled at the first pixel of a frame.
// One item is handled at a time. A pixel that yields a result first reads
// its window taps and then its centre from the line store one at a time,
// then runs the shared one-bit-per-cycle divider (four divisions per
// result). A frame's first pixel also passes the size computation; a flush
// skips the line store write.
// Reset clears position, frame and handshake state and loads register
// defaults; the line store needs no clearing. When the receiver stalls,
// the finished result waits in the output register and the block stops
// taking items only once its next result is ready to load.
// ----------------------------------------------------------------------------
module haze_transmission_recovery_unit
   import htr_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
   parameter int PATCH_SIZE = PATCH_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input: blue [7:0], green [15:8], red [23:16]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,
   // flush [0]
   input  logic                  req_tuser,
   // result: transmission [7:0], out_blue [15:8], out_green [23:16], out_red [31:24]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [4*CHAN_W-1:0]   rsp_tdata,
   // frame_last
   output logic                  rsp_tlast,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int HALF  = PATCH_SIZE / 2;
   localparam int RING  = 2 * PATCH_SIZE;
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int GW    = $clog2(RING);
   localparam int GSW   = $clog2(3 * RING);
   localparam int KW    = $clog2(PATCH_SIZE);
   localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT) + 2;
   localparam int DEPTH = RING * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = 14;

   // configuration registers
   logic [SIZE_REG_W-1:0] cfg_w_ff, cfg_h_ff;
   logic [CHAN_W-1:0]     cfg_a_ff;
   logic [Q16_W-1:0]      cfg_om_ff, cfg_tf_ff;

   // per-frame copies
   logic [WW-1:0]     lat_w_ff;
   logic [HW-1:0]     lat_h_ff;
   logic [CHAN_W-1:0] lat_a_ff;
   logic [Q16_W-1:0]  lat_om_ff, lat_tf_ff;
   logic [PW-1:0]     total_ff, lag_ff;

   // positions
   htr_state_type state_ff, state_in;
   logic          active_ff;
   logic [CW-1:0] col_ff, ocol_ff;
   logic [GW-1:0] ring_ff, oring_ff;
   logic [RW-1:0] orow_ff;
   logic [PW-1:0] pos_ff;

   // item and window work
   logic [PIXEL_W-1:0] pix_ff, center_ff, mem_q_ff;
   logic               restart_ff, last_ff, ctr_ff, rd_ok_ff;
   logic [KW-1:0]      dm_ff, dn_ff;
   logic [CHAN_W-1:0]  dark_ff;
   logic [23:0]        prod_ff;
   logic [Q16_W-1:0]   t_ff, d_ff;
   logic [1:0]         ch_ff;
   logic [CHAN_W-1:0]  res_ff [3];

   // output register
   logic                rsp_valid_ff, rsp_last_ff;
   logic [4*CHAN_W-1:0] rsp_data_ff;

   // line store
   logic [PIXEL_W-1:0] store [DEPTH];

   // sequencer outputs
   logic accept, mem_we, div_start, rsp_load;

   // divider
   logic [DIV_DVD_W-1:0] div_dvd, div_quo;
   logic [DIV_DVS_W-1:0] div_dvs;
   htr_div_stat_type     div_stat;

   // misc comb
   logic          pos_ge_total, out_ok;
   logic [PW-1:0] q_cur;
   logic [SW-1:0] mm, nn, rsum, r1, r2;
   logic          win_ok;
   logic [AW-1:0] waddr, raddr;
   logic [CW-1:0] rcol;
   logic [GW-1:0] rring;
   logic [WW-1:0] col_p1, ocol_p1;
   logic [CHAN_W-1:0] ch_in;
   logic [CHAN_W:0]   mag;
   logic [Q16_W:0]    t_calc;
   logic [Q16_W-1:0]  t_sat, d_calc;
   logic [DIV_DVD_W-1:0] cres_hi;
   logic [CHAN_W-1:0] ch_res;
   logic [23:0]       tx_prod;
   logic [CHAN_W-1:0] tx_val;

   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff  <= RST_FRAME_WIDTH;
         cfg_h_ff  <= RST_FRAME_HEIGHT;
         cfg_a_ff  <= RST_ATMOS_LIGHT;
         cfg_om_ff <= RST_OMEGA;
         cfg_tf_ff <= RST_T_FLOOR;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_w_ff  <= csr_data[SIZE_REG_W-1:0];
            CSR_FRAME_HEIGHT: cfg_h_ff  <= csr_data[SIZE_REG_W-1:0];
            CSR_ATMOS_LIGHT:  cfg_a_ff  <= csr_data[CHAN_W-1:0];
            CSR_OMEGA:        cfg_om_ff <= csr_data;
            CSR_T_FLOOR:      cfg_tf_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // frame and output position tests
   always_comb begin
      pos_ge_total = pos_ff >= total_ff;
      q_cur        = pos_ff - PW'(1) - lag_ff;
      out_ok       = (pos_ff > lag_ff) && (q_cur < total_ff);
      col_p1       = WW'(col_ff) + WW'(1);
      ocol_p1      = WW'(ocol_ff) + WW'(1);
   end

   // window read address, out-of-frame taps are skipped
   always_comb begin
      mm    = SW'(ocol_ff) + SW'(dm_ff);
      nn    = SW'(orow_ff) + SW'(dn_ff);
      rsum  = SW'(oring_ff) + SW'(dn_ff) + SW'(RING - HALF);
      r1    = (rsum >= SW'(RING)) ? rsum - SW'(RING) : rsum;
      r2    = (r1 >= SW'(RING)) ? r1 - SW'(RING) : r1;
      win_ok = (mm >= SW'(HALF)) && ((mm - SW'(HALF)) < SW'(lat_w_ff))
            && (nn >= SW'(HALF)) && ((nn - SW'(HALF)) < SW'(lat_h_ff));
      if (ctr_ff) begin
         rcol  = ocol_ff;
         rring = oring_ff;
      end else begin
         rcol  = CW'(mm - SW'(HALF));
         rring = GW'(r2);
      end
      raddr = AW'(rring) * AW'(MAX_WIDTH) + AW'(rcol);
      waddr = AW'(ring_ff) * AW'(MAX_WIDTH) + AW'(col_ff);
   end

   // line store, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) store[waddr] <= pix_ff;
      mem_q_ff <= store[raddr];
   end

   // transmission and divisor from the first quotient
   always_comb begin
      if (div_quo >= DIV_DVD_W'(65536)) t_calc = '0;
      else t_calc = (Q16_W+1)'(DIV_DVD_W'(65536) - div_quo);
      t_sat  = (t_calc > (Q16_W+1)'(65535)) ? 16'hFFFF : t_calc[Q16_W-1:0];
      d_calc = (t_sat > lat_tf_ff) ? t_sat : lat_tf_ff;
      if (d_calc == '0) d_calc = 16'd1;
   end

   // channel magnitude and recovery
   always_comb begin
      case (ch_ff)
         2'd0:    ch_in = center_ff[CHAN_W-1:0];
         2'd1:    ch_in = center_ff[2*CHAN_W-1:CHAN_W];
         default: ch_in = center_ff[3*CHAN_W-1:2*CHAN_W];
      endcase
      mag = (ch_in >= lat_a_ff) ? {1'b0, ch_in - lat_a_ff} : {1'b0, lat_a_ff - ch_in};
      if (ch_in >= lat_a_ff) begin
         cres_hi = DIV_DVD_W'(lat_a_ff) + div_quo;
         ch_res  = (cres_hi > DIV_DVD_W'(255)) ? 8'hFF : cres_hi[CHAN_W-1:0];
      end else begin
         cres_hi = DIV_DVD_W'(lat_a_ff) - div_quo;
         ch_res  = (div_quo >= DIV_DVD_W'(lat_a_ff)) ? 8'h00 : cres_hi[CHAN_W-1:0];
      end
      tx_prod = 24'(t_ff) * 24'(255) + 24'(32768);
      tx_val  = tx_prod[23:16];
   end

   // divider operands
   always_comb begin
      if (state_ff == S_DIVA_GO) begin
         div_dvd = DIV_DVD_W'(prod_ff);
         div_dvs = DIV_DVS_W'(lat_a_ff);
      end else begin
         div_dvd = DIV_DVD_W'({mag[CHAN_W-1:0], 16'h0000}) + DIV_DVD_W'(d_ff >> 1);
         div_dvs = d_ff;
      end
   end

   htr_div #(
      .DW(DIV_DVD_W),
      .VW(DIV_DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!req_tuser) state_in = (!active_ff || pos_ge_total) ? S_LATCH : S_WRITE;
               else if (active_ff && pos_ge_total) state_in = S_CHECK;
            end
         end
         S_LATCH:     state_in = S_WRITE;
         S_WRITE:     state_in = S_CHECK;
         S_CHECK:     state_in = out_ok ? S_RADDR : S_IDLE;
         S_RADDR:     state_in = S_RDATA;
         S_RDATA:     state_in = ctr_ff ? S_MUL : S_RADDR;
         S_MUL:       state_in = S_DIVA_GO;
         S_DIVA_GO:   state_in = S_DIVA_WAIT;
         S_DIVA_WAIT: if (div_stat.done) state_in = S_DIVC_GO;
         S_DIVC_GO:   state_in = S_DIVC_WAIT;
         S_DIVC_WAIT: if (div_stat.done) state_in = (ch_ff == 2'd2) ? S_DONE : S_DIVC_GO;
         S_DONE:      if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         S_IDLE:    req_tready = 1'b1;
         S_WRITE:   mem_we     = 1'b1;
         S_DIVA_GO: div_start  = 1'b1;
         S_DIVC_GO: div_start  = 1'b1;
         S_DONE:    rsp_load   = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         active_ff <= 1'b0;
         col_ff    <= '0;
         ring_ff   <= '0;
         pos_ff    <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         oring_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // restart a frame on its first pixel
         if (accept && !req_tuser && (!active_ff || pos_ge_total)) begin
            active_ff <= 1'b1;
            col_ff    <= '0;
            ring_ff   <= '0;
            pos_ff    <= '0;
            ocol_ff   <= '0;
            orow_ff   <= '0;
            oring_ff  <= '0;
         end
         // advance the arrival position
         if (mem_we || (accept && req_tuser && active_ff && pos_ge_total)) begin
            pos_ff <= pos_ff + PW'(1);
            if (col_p1 >= lat_w_ff) begin
               col_ff  <= '0;
               ring_ff <= (ring_ff == GW'(RING - 1)) ? '0 : ring_ff + GW'(1);
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end
         // output position and end of frame
         if (rsp_load) begin
            if (last_ff) begin
               active_ff <= 1'b0;
               col_ff    <= '0;
               ring_ff   <= '0;
               pos_ff    <= '0;
               ocol_ff   <= '0;
               orow_ff   <= '0;
               oring_ff  <= '0;
            end else if (ocol_p1 >= lat_w_ff) begin
               ocol_ff  <= '0;
               orow_ff  <= orow_ff + RW'(1);
               oring_ff <= (oring_ff == GW'(RING - 1)) ? '0 : oring_ff + GW'(1);
            end else begin
               ocol_ff <= ocol_ff + CW'(1);
            end
         end
         // result handshake
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff     <= req_tdata;
         restart_ff <= !req_tuser && (!active_ff || pos_ge_total);
      end
      if (accept && !req_tuser && (!active_ff || pos_ge_total)) begin
         if (cfg_w_ff == '0) lat_w_ff <= WW'(1);
         else if (13'(cfg_w_ff) > 13'(MAX_WIDTH)) lat_w_ff <= WW'(MAX_WIDTH);
         else lat_w_ff <= WW'(cfg_w_ff);
         if (cfg_h_ff == '0) lat_h_ff <= HW'(1);
         else if (13'(cfg_h_ff) > 13'(MAX_HEIGHT)) lat_h_ff <= HW'(MAX_HEIGHT);
         else lat_h_ff <= HW'(cfg_h_ff);
         lat_a_ff  <= (cfg_a_ff == '0) ? 8'd1 : cfg_a_ff;
         lat_om_ff <= cfg_om_ff;
         lat_tf_ff <= cfg_tf_ff;
      end
      if (state_ff == S_LATCH) begin
         total_ff <= PW'(lat_w_ff) * PW'(lat_h_ff);
         lag_ff   <= PW'(HALF) * PW'(lat_w_ff) + PW'(HALF);
      end
      if (state_ff == S_CHECK) begin
         last_ff <= q_cur == (total_ff - PW'(1));
         dm_ff   <= '0;
         dn_ff   <= '0;
         ctr_ff  <= 1'b0;
         dark_ff <= 8'hFF;
      end
      if (state_ff == S_RADDR) rd_ok_ff <= win_ok || ctr_ff;
      // fold one tap into the dark value
      if (state_ff == S_RDATA) begin
         if (ctr_ff) begin
            center_ff <= mem_q_ff;
         end else begin
            if (rd_ok_ff && (min3(mem_q_ff) < dark_ff)) dark_ff <= min3(mem_q_ff);
            if (dn_ff == KW'(PATCH_SIZE - 1)) begin
               dn_ff <= '0;
               if (dm_ff == KW'(PATCH_SIZE - 1)) ctr_ff <= 1'b1;
               else dm_ff <= dm_ff + KW'(1);
            end else begin
               dn_ff <= dn_ff + KW'(1);
            end
         end
      end
      if (state_ff == S_MUL)
         prod_ff <= 24'(lat_om_ff) * 24'(dark_ff) + 24'(lat_a_ff >> 1);
      if (state_ff == S_DIVA_WAIT && div_stat.done) begin
         t_ff  <= t_sat;
         d_ff  <= d_calc;
         ch_ff <= 2'd0;
      end
      if (state_ff == S_DIVC_WAIT && div_stat.done) begin
         res_ff[ch_ff] <= ch_res;
         ch_ff         <= ch_ff + 2'd1;
      end
      if (rsp_load) begin
         rsp_data_ff <= {res_ff[2], res_ff[1], res_ff[0], tx_val};
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // position is home whenever no frame is open
   a_idle_home: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (pos_ff == '0 && col_ff == '0 && ocol_ff == '0))
      else $error("position not cleared outside a frame");

   // divider completes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIVA_WAIT || state_ff == S_DIVC_WAIT))
      else $error("divider result with no consumer");

   // output column stays inside the latched width
   a_ocol_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (WW'(ocol_ff) < lat_w_ff))
      else $error("output column beyond frame width");

   // the size computation runs only for a restarted item
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LATCH) |-> restart_ff)
      else $error("size computation without frame restart");

endmodule

[tb/tb_haze_transmission_recovery_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_haze_transmission_recovery_unit
// Self-checking bench for the dark channel prior dehaze unit.
// ----------------------------------------------------------------------------
// Pixel frames of mostly small sizes are streamed in raster order, each
// followed by the flush transfers that drain its tail. A behavioral model
// of the window minimum, transmission and recovery math predicts every
// result, and each result transfer is compared field by field in order.
// Both stream sides idle and stall at random. Registers are rewritten
// between frames, limits included.
// ----------------------------------------------------------------------------
module tb_haze_transmission_recovery_unit;
   import htr_pkg::*;

   localparam int MAX_W    = MAX_WIDTH_DEF;
   localparam int MAX_H    = MAX_HEIGHT_DEF;
   localparam int PATCH    = PATCH_SIZE_DEF;
   localparam int HALF     = PATCH / 2;
   localparam int RING     = 2 * PATCH;
   localparam int SETTLE   = 300;

   typedef struct {
      logic [7:0] trans;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       last;
   } dehaze_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [4*CHAN_W-1:0]   rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   haze_transmission_recovery_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected results and bookkeeping
   dehaze_result_type expected_pixels[$];
   int error_count   = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int frames_sent   = 0;
   int send_gap_max  = 12;
   int recv_stall_max = 12;

   // model state
   logic [PIXEL_W-1:0] line_mem [RING][MAX_W];
   int unsigned col_pos, row_pos;
   bit          frame_on;
   int unsigned reg_w, reg_h, reg_a, reg_om, reg_tf;
   int unsigned cur_w, cur_h, cur_a, cur_om, cur_tf;

   function automatic int unsigned clamp_size(int unsigned v, int unsigned lim);
      return (v == 0) ? 1 : ((v > lim) ? lim : v);
   endfunction

   function automatic void latch_regs();
      cur_w  = clamp_size(reg_w, MAX_W);
      cur_h  = clamp_size(reg_h, MAX_H);
      cur_a  = (reg_a == 0) ? 1 : reg_a;
      cur_om = reg_om;
      cur_tf = reg_tf;
   endfunction

   function automatic void step_position();
      col_pos++;
      if (col_pos >= cur_w) begin
         col_pos = 0;
         row_pos++;
      end
   endfunction

   function automatic logic [7:0] recover_chan(int unsigned i, int unsigned a,
                                               longint unsigned d);
      longint unsigned qt;
      if (i >= a) begin
         qt = ((longint'(i - a) << 16) + (d >> 1)) / d;
         return (a + qt > 255) ? 8'd255 : 8'(a + qt);
      end
      qt = ((longint'(a - i) << 16) + (d >> 1)) / d;
      return (qt >= a) ? 8'd0 : 8'(a - qt);
   endfunction

   // predict the result caused by one accepted transfer
   function automatic void predict_dehaze(logic [PIXEL_W-1:0] px, bit flush);
      int unsigned total, pos, lag, q, r, c, dark, cm;
      int m, n;
      longint unsigned qd, t, d;
      logic [PIXEL_W-1:0] cell_px;
      dehaze_result_type res;
      total = cur_w * cur_h;
      pos = row_pos * cur_w + col_pos;
      if (!flush) begin
         if (!frame_on || pos >= total) begin
            latch_regs();
            frame_on = 1;
            row_pos = 0;
            col_pos = 0;
            total = cur_w * cur_h;
         end
         line_mem[row_pos % RING][col_pos] = px;
         step_position();
      end else begin
         if (!frame_on || pos < total) return;
         step_position();
      end
      pos = row_pos * cur_w + col_pos;
      lag = HALF * cur_w + HALF;
      if (pos <= lag) return;
      q = pos - 1 - lag;
      if (q >= total) return;
      r = q / cur_w;
      c = q % cur_w;
      // window minimum, skipping positions off the frame
      dark = 255;
      for (int dm = 0; dm < PATCH; dm++) begin
         m = int'(c) + dm - HALF;
         cm = 255;
         if (m >= 0 && m < int'(cur_w))
            for (int dn = 0; dn < PATCH; dn++) begin
               n = int'(r) + dn - HALF;
               if (n < 0 || n >= int'(cur_h)) continue;
               cell_px = line_mem[n % RING][m];
               for (int k = 0; k < 3; k++)
                  if (cell_px[8*k +: 8] < cm) cm = cell_px[8*k +: 8];
            end
         if (cm < dark) dark = cm;
      end
      qd = (longint'(cur_om) * dark + (cur_a >> 1)) / cur_a;
      t = (qd >= 65536) ? 0 : 65536 - qd;
      if (t > 65535) t = 65535;
      d = (t > cur_tf) ? t : cur_tf;
      if (d == 0) d = 1;
      cell_px = line_mem[r % RING][c];
      res.trans = 8'((t * 255 + 32768) >> 16);
      res.blue  = recover_chan(cell_px[7:0], cur_a, d);
      res.green = recover_chan(cell_px[15:8], cur_a, d);
      res.red   = recover_chan(cell_px[23:16], cur_a, d);
      res.last  = (q == total - 1);
      if (res.last) begin
         frame_on = 0;
         row_pos = 0;
         col_pos = 0;
      end
      expected_pixels.push_back(res);
   endfunction

   task automatic report_mismatch(string what, int exp_v, int got_v);
      error_count++;
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
   endtask

   // one item transfer, with a random idle gap in front
   task automatic send_item(logic [PIXEL_W-1:0] px, bit flush);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= flush;
      do @(posedge clock); while (!req_tready);
      predict_dehaze(px, flush);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[15:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FRAME_WIDTH:  reg_w  = val & 32'h7FF;
         CSR_FRAME_HEIGHT: reg_h  = val & 32'h7FF;
         CSR_ATMOS_LIGHT:  reg_a  = val & 32'hFF;
         CSR_OMEGA:        reg_om = val & 32'hFFFF;
         CSR_T_FLOOR:      reg_tf = val & 32'hFFFF;
         default: ;
      endcase
   endtask

   task automatic set_regs(int unsigned w, int unsigned h, int unsigned a,
                           int unsigned om, int unsigned tf);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_ATMOS_LIGHT, a);
      write_reg(CSR_OMEGA, om);
      write_reg(CSR_T_FLOOR, tf);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [PIXEL_W-1:0] make_pixel(int kind);
      case (kind)
         1: return '0;
         2: return '1;
         3: return {{$urandom_range(0, 1) ? 8'hFF : 8'h00},
                    {$urandom_range(0, 1) ? 8'hFF : 8'h00},
                    {$urandom_range(0, 1) ? 8'hFF : 8'h00}};
         default: return PIXEL_W'($urandom);
      endcase
   endfunction

   // full frame at current register values; drains fully unless told otherwise
   task automatic send_frame(int kind, int flushes = -1);
      int unsigned w, h;
      w = clamp_size(reg_w, MAX_W);
      h = clamp_size(reg_h, MAX_H);
      for (int i = 0; i < w * h; i++) send_item(make_pixel(kind), 1'b0);
      if (flushes < 0) flushes = HALF * w + HALF;
      for (int i = 0; i < flushes; i++) send_item('0, 1'b1);
      frames_sent++;
   endtask

   // result side: random stalls, in-order field compare
   initial begin
      int stall;
      dehaze_result_type exp_r;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, recv_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_seen++;
         if (expected_pixels.size() == 0) begin
            error_count++;
            $display("[%0t] result transfer with none expected", $time);
         end else begin
            exp_r = expected_pixels.pop_front();
            if (rsp_tdata[7:0] !== exp_r.trans)
               report_mismatch("transmission", exp_r.trans, rsp_tdata[7:0]);
            if (rsp_tdata[15:8] !== exp_r.blue)
               report_mismatch("out_blue", exp_r.blue, rsp_tdata[15:8]);
            if (rsp_tdata[23:16] !== exp_r.green)
               report_mismatch("out_green", exp_r.green, rsp_tdata[23:16]);
            if (rsp_tdata[31:24] !== exp_r.red)
               report_mismatch("out_red", exp_r.red, rsp_tdata[31:24]);
            if (rsp_tlast !== exp_r.last)
               report_mismatch("frame_last", exp_r.last, rsp_tlast);
         end
      end
   end

   // flat and extreme pixels, tiny frames, zero omega and zero floor
   task automatic test_directed_extremes();
      set_regs(1, 1, 255, 0, 0);
      send_frame(2);
      send_frame(1);
      wait_drained();
      set_regs(3, 2, 1, 65535, 0);
      send_frame(3);
      wait_drained();
      set_regs(4, 3, 128, 62259, 65535);
      send_frame(0);
      wait_drained();
   endtask

   // sizes out of range, zero light
   task automatic test_register_limits();
      set_regs(0, 0, 0, 32768, 6554);
      send_frame(0);
      wait_drained();
      // width above the maximum: one full row, flushed just past the first result
      set_regs(2047, 1, 100, 40000, 1000);
      send_frame(0, 2);
      wait_drained();
      // a single-pixel frame restarts during the drain and closes cleanly
      set_regs(1, 1, 100, 40000, 1000);
      send_frame(0);
      wait_drained();
   endtask

   // flushes while idle and mid-frame are ignored
   task automatic test_early_flush();
      set_regs(3, 3, 180, 62259, 6554);
      send_item('0, 1'b1);
      send_item('0, 1'b1);
      for (int i = 0; i < 9; i++) begin
         send_item(make_pixel(0), 1'b0);
         if (i == 4) send_item('0, 1'b1);
      end
      for (int i = 0; i < HALF * 3 + HALF; i++) send_item('0, 1'b1);
      send_item('0, 1'b1);
      wait_drained();
   endtask

   // a new frame starting during the drain drops the pending tail
   task automatic test_pixel_during_drain();
      set_regs(4, 3, 220, 50000, 3000);
      send_frame(0, 2);
      send_frame(0);
      wait_drained();
   endtask

   // random frames, mostly small, with register changes between them
   task automatic test_random_frames();
      int pick;
      while (items_sent < 1700) begin
         pick = $urandom_range(0, 9);
         send_gap_max   = (pick < 2) ? 0 : 12;
         recv_stall_max = (pick == 2) ? 0 : 12;
         set_regs($urandom_range(1, 8), $urandom_range(1, 6),
                  (pick == 3) ? 255 : $urandom_range(1, 255),
                  (pick == 4) ? 65535 : $urandom_range(0, 65535),
                  (pick == 5) ? 0 : $urandom_range(0, 20000));
         if (pick == 6) begin
            // hold the sender until the frame so far has fully come out
            for (int i = 0; i < 4; i++) send_item(make_pixel(0), 1'b0);
            req_tvalid <= 1'b0;
            do @(posedge clock); while (expected_pixels.size() != 0);
            send_frame(0);
         end else if (pick == 7) begin
            send_item('0, 1'b1);
            send_frame(3, 1);
            send_frame(0);
         end else begin
            send_frame(0);
         end
         wait_drained();
      end
      send_gap_max = 12;
      recv_stall_max = 12;
   endtask

   initial begin
      reg_w = RST_FRAME_WIDTH;
      reg_h = RST_FRAME_HEIGHT;
      reg_a = RST_ATMOS_LIGHT;
      reg_om = RST_OMEGA;
      reg_tf = RST_T_FLOOR;
      latch_regs();
      col_pos = 0;
      row_pos = 0;
      frame_on = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_register_limits();
      test_early_flush();
      test_pixel_during_drain();
      test_random_frames();
      wait_drained();
      $display("covered %0d frames, %0d item transfers, %0d result transfers",
               frames_sent, items_sent, results_seen);
      $display("register limits, flush handling and drain restarts included");
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d results outstanding", expected_pixels.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
hdl/htr_pkg.sv
hdl/htr_div.sv
hdl/haze_transmission_recovery_unit.sv
tb/tb_haze_transmission_recovery_unit.sv
